>>> hw/rtl/cdds_pkg.sv
package cdds_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_SET = 2'd0;
    localparam logic [1:0] CMD_ADD = 2'd1;
    localparam logic [1:0] CMD_SUB = 2'd2;

    localparam logic [13:0] YEAR_MIN = 14'd1900;
    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [13:0] YEAR_STEP = 14'd400;

    // 1900 mod 400
    localparam logic [8:0] YEAR_MIN_M400 = 9'd300;
    localparam logic [8:0] M400_LAST = 9'd399;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_ADD,
        ST_SUB,
        ST_DONE
    } t_state;

    // leap test from the year's low bits and its remainder mod 400
    function automatic logic is_leap(input logic [1:0] y_lo, input logic [8:0] m400);
        logic cent;
        cent = (m400 == 9'd100) || (m400 == 9'd200) || (m400 == 9'd300);
        return (y_lo == 2'd0) && !cent;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [1:0] y_lo,
                                             input logic [8:0] m400);
        logic [4:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            MONTH_FEB:               len = is_leap(y_lo, m400) ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> hw/rtl/calendar_date_day_stepper_top.sv
// Channel   Dir  Handshake                    Word contents
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: date to set, day count; tuser: command
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: stored date; tuser: accepted flag
//
// One word at a time. Add and subtract cross at most one month per cycle in the
// shared month-step unit. Set reduces the year mod 400 by repeated subtraction.
// Unknown commands go straight to the result with the accepted flag clear.
// Reset (synchronous, active low) loads 1900-01-01 and empties the output register.
// A stalled result sits in the output register while the next word is taken;
// the following result waits for it to drain.
module calendar_date_day_stepper_top
    import cdds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] new_day, [8:5] new_month, [22:9] new_year, [38:23] day_count, [39] zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] cur_day, [8:5] cur_month, [22:9] cur_year, [23] zero
    output logic [23:0] m_axis_tdata,
    // [0] accepted
    output logic        m_axis_tuser
);

    t_state r_state, n_state;

    // stored date, plus the year mod 400 tracked beside it for the leap rule
    logic [4:0]  r_day,   n_day;
    logic [3:0]  r_month, n_month;
    logic [13:0] r_year,  n_year;
    logic [8:0]  r_m400,  n_m400;

    // latched command operands
    logic [4:0]  r_nd,  n_nd;
    logic [3:0]  r_nm,  n_nm;
    logic [13:0] r_ny,  n_ny;
    logic [13:0] r_rem, n_rem;
    logic [15:0] r_cnt, n_cnt;
    logic        r_acc, n_acc;

    // output register
    logic        r_o_valid, n_o_valid;
    logic [4:0]  r_o_day,   n_o_day;
    logic [3:0]  r_o_month, n_o_month;
    logic [13:0] r_o_year,  n_o_year;
    logic        r_o_acc,   n_o_acc;

    // shared month-step unit
    logic [4:0]  cur_len;     // length of the current month
    logic [4:0]  room;        // days left in the current month
    logic [15:0] room_ext;
    logic [8:0]  m400_inc, m400_dec;
    logic [3:0]  prev_month;
    logic [13:0] prev_year;
    logic [8:0]  prev_m400;
    logic [4:0]  prev_len;    // length of the month being stepped back into
    logic [4:0]  set_len;
    logic        set_ok;

    always_comb begin
        cur_len    = month_len(r_month, r_year[1:0], r_m400);
        room       = cur_len - r_day;
        room_ext   = {11'd0, room};
        m400_inc   = (r_m400 == M400_LAST) ? 9'd0 : r_m400 + 9'd1;
        m400_dec   = (r_m400 == 9'd0) ? M400_LAST : r_m400 - 9'd1;
        prev_month = (r_month == MONTH_JAN) ? MONTH_DEC : r_month - 4'd1;
        prev_year  = (r_month == MONTH_JAN) ? r_year - 14'd1 : r_year;
        prev_m400  = (r_month == MONTH_JAN) ? m400_dec : r_m400;
        prev_len   = month_len(prev_month, prev_year[1:0], prev_m400);
        set_len    = month_len(r_nm, r_ny[1:0], r_rem[8:0]);
        set_ok     = (r_nm >= MONTH_JAN) && (r_nm <= MONTH_DEC) &&
                     (r_ny >= YEAR_MIN) && (r_ny <= YEAR_MAX) &&
                     (r_nd != 5'd0) && (r_nd <= set_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_day     <= 5'd1;
            r_month   <= MONTH_JAN;
            r_year    <= YEAR_MIN;
            r_m400    <= YEAR_MIN_M400;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_day     <= n_day;
            r_month   <= n_month;
            r_year    <= n_year;
            r_m400    <= n_m400;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nd      <= n_nd;
        r_nm      <= n_nm;
        r_ny      <= n_ny;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_acc     <= n_acc;
        r_o_day   <= n_o_day;
        r_o_month <= n_o_month;
        r_o_year  <= n_o_year;
        r_o_acc   <= n_o_acc;
    end

    always_comb begin
        n_state   = r_state;
        n_day     = r_day;
        n_month   = r_month;
        n_year    = r_year;
        n_m400    = r_m400;
        n_nd      = r_nd;
        n_nm      = r_nm;
        n_ny      = r_ny;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_o_valid = r_o_valid && !m_axis_tready;
        n_o_day   = r_o_day;
        n_o_month = r_o_month;
        n_o_year  = r_o_year;
        n_o_acc   = r_o_acc;
        s_axis_tready = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_nd  = s_axis_tdata[4:0];
                    n_nm  = s_axis_tdata[8:5];
                    n_ny  = s_axis_tdata[22:9];
                    n_rem = s_axis_tdata[22:9];
                    n_cnt = s_axis_tdata[38:23];
                    n_acc = 1'b1;
                    case (s_axis_tuser)
                        CMD_SET: n_state = ST_MOD;
                        CMD_ADD: n_state = ST_ADD;
                        CMD_SUB: n_state = ST_SUB;
                        default: begin
                            n_acc   = 1'b0;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            // year mod 400 by repeated subtraction
            ST_MOD: begin
                if (r_rem >= YEAR_STEP) begin
                    n_rem = r_rem - YEAR_STEP;
                end else begin
                    n_state = ST_CHECK;
                end
            end

            ST_CHECK: begin
                n_acc   = set_ok;
                n_state = ST_DONE;
                if (set_ok) begin
                    n_day   = r_nd;
                    n_month = r_nm;
                    n_year  = r_ny;
                    n_m400  = r_rem[8:0];
                end
            end

            // one month per cycle; saturate past the last supported day
            ST_ADD: begin
                if (r_cnt == 16'd0) begin
                    n_state = ST_DONE;
                end else if (r_cnt <= room_ext) begin
                    n_day   = r_day + r_cnt[4:0];
                    n_cnt   = 16'd0;
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - (room_ext + 16'd1);
                    n_day = 5'd1;
                    if (r_month == MONTH_DEC) begin
                        if (r_year == YEAR_MAX) begin
                            n_day   = 5'd31;
                            n_state = ST_DONE;
                        end else begin
                            n_month = MONTH_JAN;
                            n_year  = r_year + 14'd1;
                            n_m400  = m400_inc;
                        end
                    end else begin
                        n_month = r_month + 4'd1;
                    end
                end
            end

            // one month per cycle backwards; clamp at the first supported day
            ST_SUB: begin
                if (r_cnt == 16'd0) begin
                    n_state = ST_DONE;
                end else if (r_cnt < {11'd0, r_day}) begin
                    n_day   = r_day - r_cnt[4:0];
                    n_cnt   = 16'd0;
                    n_state = ST_DONE;
                end else if (r_month == MONTH_JAN && r_year == YEAR_MIN) begin
                    n_day   = 5'd1;
                    n_cnt   = 16'd0;
                    n_state = ST_DONE;
                end else begin
                    n_cnt   = r_cnt - {11'd0, r_day};
                    n_month = prev_month;
                    n_year  = prev_year;
                    n_m400  = prev_m400;
                    n_day   = prev_len;
                end
            end

            ST_DONE: begin
                if (!r_o_valid || m_axis_tready) begin
                    n_o_valid = 1'b1;
                    n_o_day   = r_day;
                    n_o_month = r_month;
                    n_o_year  = r_year;
                    n_o_acc   = r_acc;
                    n_state   = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {1'b0, r_o_year, r_o_month, r_o_day};
    assign m_axis_tuser  = r_o_acc;

    // stored date stays a legal calendar date
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC) && (r_day != 5'd0) &&
        (r_day <= cur_len) && (r_year >= YEAR_MIN) && (r_year <= YEAR_MAX))
        else $error("stored date out of range");

    // tracked remainder agrees with the year
    a_m400_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m400 <= M400_LAST) && (r_m400[1:0] == r_year[1:0]))
        else $error("year mod 400 tracking lost");

    // one word in flight at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while busy");

    // a finished result reaches the output register
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) |=>
        (m_axis_tvalid && s_axis_tready))
        else $error("result not delivered");

endmodule

>>> tb/calendar_date_day_stepper_top_tb.sv
`timescale 1ns / 100ps

module calendar_date_day_stepper_top_tb;

    import cdds_pkg::*;

    // cmd value with no meaning; the block must leave the date alone
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    localparam int unsigned RANDOM_WORDS     = 450;
    localparam int unsigned TAIL_WORDS       = 60;
    localparam int unsigned LONG_HOLD_AFTER  = 60;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES     = 64;
    // covers the worst case, a full count on each of ~480 words, about 4x over
    localparam int unsigned LIMIT_CYCLES     = 4_000_000;

    typedef struct {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        ok;
    } t_date_word;

    // Tracks the stored date and queues the date word each command should return.
    class date_scoreboard;
        int unsigned day_q;
        int unsigned month_q;
        int unsigned year_q;
        t_date_word  expected_q[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            day_q   = 1;
            month_q = MONTH_JAN;
            year_q  = YEAR_MIN;
            errors  = 0;
            checked = 0;
        endfunction

        function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function int unsigned days_in_month(int unsigned m, int unsigned y);
            case (m)
                4, 6, 9, 11: return 30;
                MONTH_FEB:   return leap_year(y) ? 29 : 28;
                default:     return 31;
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_input(logic [1:0] cmd, logic [4:0] nd, logic [3:0] nm,
                                 logic [13:0] ny, logic [15:0] cnt);
            t_date_word  w;
            int unsigned d, m, y, n, room;
            bit          ok;
            d  = day_q;
            m  = month_q;
            y  = year_q;
            n  = cnt;
            ok = 1'b0;
            case (cmd)
                CMD_SET: begin
                    if (nm >= MONTH_JAN && nm <= MONTH_DEC && ny >= YEAR_MIN &&
                        ny <= YEAR_MAX && nd >= 1 && nd <= days_in_month(nm, ny)) begin
                        d  = nd;
                        m  = nm;
                        y  = ny;
                        ok = 1'b1;
                    end
                end
                CMD_ADD: begin
                    ok = 1'b1;
                    while (n > 0) begin
                        room = days_in_month(m, y) - d;
                        if (n <= room) begin
                            d += n;
                            n = 0;
                        end else begin
                            n -= room + 1;
                            d = 1;
                            m++;
                            if (m > MONTH_DEC) begin
                                m = MONTH_JAN;
                                y++;
                                // past the last representable day: pin at 9999-12-31
                                if (y > YEAR_MAX) begin
                                    d = 31;
                                    m = MONTH_DEC;
                                    y = YEAR_MAX;
                                    break;
                                end
                            end
                        end
                    end
                end
                CMD_SUB: begin
                    ok = 1'b1;
                    while (n > 0) begin
                        if (n < d) begin
                            d -= n;
                            n = 0;
                        end else begin
                            n -= d;
                            if (m <= MONTH_JAN) begin
                                // before the first representable day: pin at 1900-01-01
                                if (y <= YEAR_MIN) begin
                                    d = 1;
                                    m = MONTH_JAN;
                                    y = YEAR_MIN;
                                    break;
                                end
                                y--;
                                m = MONTH_DEC;
                            end else begin
                                m--;
                            end
                            d = days_in_month(m, y);
                        end
                    end
                end
                default: ;
            endcase
            day_q   = d;
            month_q = m;
            year_q  = y;
            w.day   = d[4:0];
            w.month = m[3:0];
            w.year  = y[13:0];
            w.ok    = ok;
            expected_q.push_back(w);
        endfunction

        function void compare_field(string name, logic [13:0] want, logic [13:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [23:0] word, logic ok);
            t_date_word want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %0d-%0d-%0d accepted=%0b", $time,
                         word[22:9], word[8:5], word[4:0], ok);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("cur_day",   want.day,   word[4:0]);
            compare_field("cur_month", want.month, word[8:5]);
            compare_field("cur_year",  want.year,  word[22:9]);
            compare_field("accepted",  want.ok,    ok);
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata   = '0;   // [4:0] day, [8:5] month, [22:9] year, [38:23] count
    logic [1:0]  s_axis_tuser   = '0;   // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [23:0] m_axis_tdata;          // [4:0] day, [8:5] month, [22:9] year
    logic        m_axis_tuser;          // [0] accepted

    date_scoreboard sb = new();
    bit             tail_phase = 1'b0;  // last stretch: no idling on either side
    int unsigned    gap_rate   = 0;     // percent chance of a gap before a word

    calendar_date_day_stepper_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Offer one word, possibly after an idle burst, and hold it until taken.
    task automatic send_word(input logic [1:0] cmd, input logic [4:0] nd,
                             input logic [3:0] nm, input logic [13:0] ny,
                             input logic [15:0] cnt);
        int unsigned gap;
        gap = 0;
        if (!tail_phase && $urandom_range(0, 99) < gap_rate)
            gap = $urandom_range(1, 6);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, cnt, ny, nm, nd};
        do begin
            @(posedge i_clk);
        end while (!(s_axis_tvalid && s_axis_tready));
        sb.note_input(cmd, nd, nm, ny, cnt);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Sink side: short random stalls, long ready stretches, and one long hold-off
    // so the block fills up and pushes back on its input.
    initial begin : sink_ready
        int unsigned span;
        bit          long_hold_done;
        long_hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!long_hold_done && sb.checked >= LONG_HOLD_AFTER) begin
                m_axis_tready  <= 1'b0;
                span           = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                span          = $urandom_range(1, 6);
            end else begin
                m_axis_tready <= 1'b1;
                span = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 12);
            end
            repeat (span) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: cycle limit reached with %0d words outstanding", $time, sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [1:0]  cmd;
        logic [4:0]  nd;
        logic [3:0]  nm;
        logic [13:0] ny;
        logic [15:0] cnt;
        int unsigned pick;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: from the reset date 1900-01-01
        send_word(CMD_ADD, 5'd0,  4'd0,  14'd0,    16'd0);      // zero count
        send_word(CMD_SUB, 5'd0,  4'd0,  14'd0,    16'd1);      // clamps at the floor
        send_word(CMD_ADD, 5'd0,  4'd0,  14'd0,    16'd30);     // to 31 Jan
        send_word(CMD_ADD, 5'd0,  4'd0,  14'd0,    16'd1);      // end of month rolls to 1 Feb
        send_word(CMD_ADD, 5'd0,  4'd0,  14'd0,    16'd28);     // 1900 not leap: 1 Mar
        // set: leap rule and out-of-range fields
        send_word(CMD_SET, 5'd29, 4'd2,  14'd1900, 16'd0);      // century, not leap
        send_word(CMD_SET, 5'd29, 4'd2,  14'd2000, 16'd0);      // 400-year leap
        send_word(CMD_SET, 5'd29, 4'd2,  14'd2100, 16'd0);
        send_word(CMD_SET, 5'd31, 4'd4,  14'd2023, 16'd0);      // day past month length
        send_word(CMD_SET, 5'd0,  4'd5,  14'd2023, 16'd0);      // day zero
        send_word(CMD_SET, 5'd1,  4'd0,  14'd2023, 16'd0);      // month zero
        send_word(CMD_SET, 5'd1,  4'd13, 14'd2023, 16'd0);
        send_word(CMD_SET, 5'd31, 4'd15, 14'd9999, 16'd0);
        send_word(CMD_SET, 5'd1,  4'd1,  14'd1899, 16'd0);      // year below range
        send_word(CMD_SET, 5'd1,  4'd1,  14'd0,    16'd0);
        // top of the range
        send_word(CMD_SET, 5'd31, 4'd12, 14'd9999, 16'd0);
        send_word(CMD_ADD, 5'd0,  4'd0,  14'd0,    16'd1);      // saturates
        send_word(CMD_SUB, 5'd0,  4'd0,  14'd0,    16'd65535);
        send_word(CMD_ADD, 5'd31, 4'd15, 14'd9999, 16'd65535);
        // bottom of the range
        send_word(CMD_SET, 5'd5,  4'd1,  14'd1900, 16'd0);
        send_word(CMD_SUB, 5'd0,  4'd0,  14'd0,    16'd10);     // clamps
        send_word(CMD_SUB, 5'd0,  4'd0,  14'd0,    16'd0);
        send_word(CMD_UNKNOWN, 5'd31, 4'd15, 14'd9999, 16'd65535);
        // year boundary both ways
        send_word(CMD_SET, 5'd31, 4'd12, 14'd1999, 16'd0);
        send_word(CMD_ADD, 5'd0,  4'd0,  14'd0,    16'd1);
        send_word(CMD_SUB, 5'd0,  4'd0,  14'd0,    16'd1);

        for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
            // idling density changes every 32 words, with calm stretches among them
            if (i % 32 == 0) begin
                pick = $urandom_range(0, 2);
                gap_rate = (pick == 0) ? 0 : (pick == 1) ? 25 : 50;
            end
            tail_phase = (i >= RANDOM_WORDS - TAIL_WORDS);

            // unused fields carry noise
            nd  = $urandom_range(0, 31);
            nm  = $urandom_range(0, 15);
            ny  = $urandom_range(0, 9999);
            cnt = $urandom_range(0, 65535);

            pick = $urandom_range(0, 99);
            if (pick < 30)      cmd = CMD_SET;
            else if (pick < 63) cmd = CMD_ADD;
            else if (pick < 96) cmd = CMD_SUB;
            else                cmd = CMD_UNKNOWN;

            if (cmd == CMD_SET && $urandom_range(0, 9) < 7) begin
                // valid date, years weighted to the range ends and to centuries
                pick = $urandom_range(0, 99);
                if (pick < 20)      ny = $urandom_range(YEAR_MIN, YEAR_MIN + 5);
                else if (pick < 40) ny = $urandom_range(YEAR_MAX - 5, YEAR_MAX);
                else if (pick < 55) ny = $urandom_range(19, 99) * 100;
                else                ny = $urandom_range(YEAR_MIN, YEAR_MAX);
                nm = $urandom_range(MONTH_JAN, MONTH_DEC);
                nd = $urandom_range(1, sb.days_in_month(nm, ny));
            end else if (cmd == CMD_ADD || cmd == CMD_SUB) begin
                // mostly short counts; long ones are costly in cycles
                pick = $urandom_range(0, 99);
                if (pick < 50)      cnt = $urandom_range(0, 40);
                else if (pick < 80) cnt = $urandom_range(0, 400);
                else if (pick < 92) cnt = $urandom_range(0, 5000);
                else if (pick < 97) cnt = $urandom_range(5000, 65535);
                else                cnt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            send_word(cmd, nd, nm, ny, cnt);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cdds_pkg.sv
hw/rtl/calendar_date_day_stepper_top.sv
tb/calendar_date_day_stepper_top_tb.sv
